[rtl/core/swrs_pkg.sv]
// Shared constants and types for the sliding window regression slope block.
package swrs_pkg;

	localparam int PRICE_W = 32;
	localparam int PERIOD_W = 8;
	localparam int MAX_WINDOW = 256;
	localparam int ADDR_W = $clog2(MAX_WINDOW);
	localparam int FILL_W = ADDR_W + 1;
	localparam int FRACTION_BITS = 16;
	localparam int SP_W = 41;
	localparam int SW_W = 49;
	localparam int TERM_W = 51;
	localparam int NUM_W = 56;
	localparam int DEN_W = 24;
	localparam int SLOPE_W = 49;
	localparam int DIVIDEND_W = NUM_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} job_t;

endpackage

[rtl/core/sliding_window_regression_slope.sv]
// Top level of the sliding window least-squares regression slope block.
// The front end accepts a new sample only once it has finished the previous one and the job queue is not full.
// The divider works on one slope at a time and takes the next job only after its result is accepted.
// Reset clears history and sets period to 20; the sample ring needs no clearing.
module sliding_window_regression_slope (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [swrs_pkg::PRICE_W-1:0] close_price,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [swrs_pkg::PERIOD_W-1:0] period,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [swrs_pkg::SLOPE_W-1:0] slope
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	swrs_pkg::job_t push_job;
	swrs_pkg::job_t pop_job;

	swrs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .close_price(close_price),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .period(period),
		.q_full(q_full), .q_push(q_push), .q_job(push_job)
	);

	swrs_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_job(push_job), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_job(pop_job)
	);

	swrs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_pop(q_pop), .q_job(pop_job),
		.out_valid(out_valid), .out_stall(out_stall), .slope(slope)
	);

endmodule

[rtl/core/swrs_front.sv]
// Front end: sample ring, running sums, numerator and denominator of each slope.
module swrs_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [swrs_pkg::PRICE_W-1:0] close_price,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [swrs_pkg::PERIOD_W-1:0] period,
	input  logic q_full,
	output logic q_push,
	output swrs_pkg::job_t q_job
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_A = 3'd2;
	localparam logic [2:0] S_B = 3'd3;
	localparam logic [2:0] S_C = 3'd4;
	localparam logic [2:0] S_D = 3'd5;

	logic [2:0] state_q;
	logic [swrs_pkg::PERIOD_W-1:0] period_q;
	logic [swrs_pkg::ADDR_W-1:0] wp_q;
	logic [swrs_pkg::FILL_W-1:0] fill_q;
	logic seen_q;
	logic full_q;
	logic signed [swrs_pkg::SP_W-1:0] sp_q;
	logic signed [swrs_pkg::SW_W-1:0] sw_q;
	logic signed [swrs_pkg::PRICE_W-1:0] price_q;
	logic signed [swrs_pkg::PRICE_W-1:0] rdata_q;
	logic signed [swrs_pkg::PRICE_W+swrs_pkg::FILL_W:0] prod_q;
	logic signed [swrs_pkg::TERM_W-1:0] t_q;
	logic [2*swrs_pkg::FILL_W-1:0] nn_q;
	logic signed [swrs_pkg::PRICE_W-1:0] mem [swrs_pkg::MAX_WINDOW];

	logic cfg_wr;
	logic take;
	logic [swrs_pkg::FILL_W-1:0] win;
	logic [swrs_pkg::FILL_W-1:0] weight;
	logic [swrs_pkg::ADDR_W-1:0] old_addr;
	logic signed [swrs_pkg::TERM_W-1:0] sw_next;
	logic signed [swrs_pkg::NUM_W-1:0] num;
	logic [swrs_pkg::DEN_W-1:0] den;

	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_wr = cfg_valid && cfg_ready;
	assign in_stall = !(state_q == S_IDLE) || q_full || cfg_valid;
	assign take = in_valid && !in_stall;
	assign win = {1'b0, period_q} + swrs_pkg::FILL_W'(1);
	assign weight = full_q ? fill_q - swrs_pkg::FILL_W'(1) : fill_q;
	assign old_addr = wp_q - fill_q[swrs_pkg::ADDR_W-1:0];
	assign sw_next = full_q ?
		swrs_pkg::TERM_W'(sw_q) - swrs_pkg::TERM_W'(sp_q) + swrs_pkg::TERM_W'(prod_q) :
		swrs_pkg::TERM_W'(sw_q) + swrs_pkg::TERM_W'(prod_q);
	assign num = (swrs_pkg::NUM_W'(sw_q) <<< 3) + (swrs_pkg::NUM_W'(sw_q) <<< 2)
		- (swrs_pkg::NUM_W'(t_q) <<< 2) - (swrs_pkg::NUM_W'(t_q) <<< 1);
	assign den = swrs_pkg::DEN_W'((swrs_pkg::DEN_W'(nn_q) - swrs_pkg::DEN_W'(1)) * fill_q);
	assign q_push = (state_q == S_D);
	assign q_job.num = (fill_q < swrs_pkg::FILL_W'(2)) ? '0 : num;
	assign q_job.den = (fill_q < swrs_pkg::FILL_W'(2)) ? swrs_pkg::DEN_W'(1) : den;

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rdata_q <= mem[old_addr];
		end
		if (state_q == S_B) begin
			mem[wp_q] <= price_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			price_q <= close_price;
		end
		if (state_q == S_A) begin
			prod_q <= $signed({1'b0, weight}) * price_q;
		end
		if (state_q == S_C) begin
			t_q <= $signed({1'b0, fill_q - swrs_pkg::FILL_W'(1)}) * swrs_pkg::TERM_W'(sp_q);
			nn_q <= fill_q * fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			period_q <= swrs_pkg::PERIOD_W'(20);
			wp_q <= '0;
			fill_q <= '0;
			seen_q <= 1'b0;
			full_q <= 1'b0;
			sp_q <= '0;
			sw_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_wr) begin
						period_q <= period;
						wp_q <= '0;
						fill_q <= '0;
						seen_q <= 1'b0;
						sp_q <= '0;
						sw_q <= '0;
					end else if (take) begin
						full_q <= (fill_q >= win);
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_A;
				S_A: begin
					if (full_q) begin
						sp_q <= sp_q - swrs_pkg::SP_W'(rdata_q);
					end
					state_q <= S_B;
				end
				S_B: begin
					sw_q <= sw_next[swrs_pkg::SW_W-1:0];
					sp_q <= sp_q + swrs_pkg::SP_W'(price_q);
					if (!full_q) begin
						fill_q <= fill_q + swrs_pkg::FILL_W'(1);
					end
					wp_q <= wp_q + swrs_pkg::ADDR_W'(1);
					seen_q <= 1'b1;
					state_q <= seen_q ? S_C : S_IDLE;
				end
				S_C: state_q <= S_D;
				S_D: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/swrs_queue.sv]
// Two-entry queue of division jobs between the front and back ends.
module swrs_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  swrs_pkg::job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output swrs_pkg::job_t pop_job
);

	swrs_pkg::job_t slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= !wr_q;
			end
			if (pop && !empty) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

[rtl/core/swrs_back.sv]
// Back end: bit-serial divider with saturation and the output register.
module swrs_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  swrs_pkg::job_t q_job,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [swrs_pkg::SLOPE_W-1:0] slope
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV = 2'd1;
	localparam logic [1:0] B_FIN = 2'd2;
	localparam logic [1:0] B_OUT = 2'd3;
	localparam logic [swrs_pkg::DIVIDEND_W-1:0] POS_LIM =
		swrs_pkg::DIVIDEND_W'((swrs_pkg::DIVIDEND_W'(1) << (swrs_pkg::SLOPE_W - 1)) - 1);
	localparam logic [swrs_pkg::DIVIDEND_W-1:0] NEG_LIM =
		swrs_pkg::DIVIDEND_W'(1) << (swrs_pkg::SLOPE_W - 1);

	logic [1:0] state_q;
	logic [swrs_pkg::CNT_W-1:0] cnt_q;
	logic neg_q;
	logic [swrs_pkg::DIVIDEND_W-1:0] dvd_q;
	logic [swrs_pkg::DIVIDEND_W-1:0] quo_q;
	logic [swrs_pkg::DEN_W-1:0] rem_q;
	logic [swrs_pkg::DEN_W-1:0] den_q;
	logic signed [swrs_pkg::SLOPE_W-1:0] slope_q;

	logic [swrs_pkg::NUM_W-1:0] mag;
	logic [swrs_pkg::DEN_W:0] trial;
	logic fits;
	logic [swrs_pkg::DIVIDEND_W-1:0] lim;
	logic [swrs_pkg::DIVIDEND_W-1:0] res;

	assign q_pop = (state_q == B_IDLE) && !q_empty;
	assign mag = q_job.num[swrs_pkg::NUM_W-1] ? swrs_pkg::NUM_W'(-q_job.num) :
		swrs_pkg::NUM_W'(q_job.num);
	assign trial = {rem_q, dvd_q[swrs_pkg::DIVIDEND_W-1]};
	assign fits = (trial >= {1'b0, den_q});
	assign lim = neg_q ? NEG_LIM : POS_LIM;
	assign res = (quo_q > lim) ? lim : quo_q;
	assign out_valid = (state_q == B_OUT);
	assign slope = slope_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					neg_q <= q_job.num[swrs_pkg::NUM_W-1];
					dvd_q <= {mag, {swrs_pkg::FRACTION_BITS{1'b0}}};
					den_q <= q_job.den;
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			B_DIV: begin
				rem_q <= fits ? swrs_pkg::DEN_W'(trial - {1'b0, den_q}) :
					trial[swrs_pkg::DEN_W-1:0];
				quo_q <= {quo_q[swrs_pkg::DIVIDEND_W-2:0], fits};
				dvd_q <= dvd_q << 1;
			end
			B_FIN: begin
				slope_q <= neg_q ? swrs_pkg::SLOPE_W'(-res) : swrs_pkg::SLOPE_W'(res);
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						cnt_q <= swrs_pkg::CNT_W'(swrs_pkg::DIVIDEND_W - 1);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q - swrs_pkg::CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: state_q <= B_OUT;
				B_OUT: begin
					if (!out_stall) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/swrs_checker.sv]
// Port-level checker for the regression slope block, bound to the top level.
module swrs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic out_valid,
	input logic out_stall,
	input logic [swrs_pkg::SLOPE_W-1:0] slope
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("slope request dropped");

	a_hold_slope: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(slope)) else $error("stalled slope changed");

	a_no_cfg_and_input: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && in_valid && !in_stall))
		else $error("sample taken with period write");

	a_no_back_to_back_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid) else $error("results too close");

	a_first_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !out_valid) else $error("result after period write");

endmodule

bind sliding_window_regression_slope swrs_checker u_swrs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .out_valid(out_valid),
	.out_stall(out_stall), .slope(slope)
);

[verif/tb_sliding_window_regression_slope.sv]
// Randomized self-checking testbench for the sliding window regression slope block.
class slope_scoreboard;
	bit [31:0] ring[256];
	int unsigned head;
	int unsigned fill;
	int unsigned period_reg;
	bit seen;
	longint sum_p;
	longint sum_wp;
	bit [48:0] pending_slopes[$];
	int errors;

	function new();
		period_reg = 20;
		errors = 0;
		clear();
	endfunction

	function void clear();
		head = 0;
		fill = 0;
		seen = 0;
		sum_p = 0;
		sum_wp = 0;
	endfunction

	function void set_period(int unsigned p);
		period_reg = p;
		clear();
	endfunction

	function bit [48:0] divide(longint num, longint unsigned d);
		bit neg;
		longint unsigned mag, lim, q, r, res;
		neg = num < 0;
		mag = neg ? -num : num;
		lim = neg ? (64'd1 << 48) : ((64'd1 << 48) - 1);
		q = mag / d;
		r = mag % d;
		if (q > (lim >> 16)) begin
			res = lim;
		end else begin
			res = q << 16;
			for (int i = 15; i >= 0; i--) begin
				r = r << 1;
				if (r >= d) begin
					r -= d;
					res |= 64'd1 << i;
				end
			end
			if (res > lim)
				res = lim;
		end
		if (neg)
			res = -res;
		return res[48:0];
	endfunction

	function void note_sample(bit [31:0] price);
		longint p, old_p, a;
		int unsigned w;
		longint unsigned n;
		p = longint'(signed'(price));
		w = period_reg + 1;
		if (w > 256)
			w = 256;
		if (fill < w) begin
			sum_p += p;
			sum_wp += longint'(fill) * p;
			fill++;
		end else begin
			old_p = longint'(signed'(ring[(head + 256 - fill) % 256]));
			sum_p -= old_p;
			sum_wp -= sum_p;
			sum_p += p;
			sum_wp += longint'(fill - 1) * p;
		end
		ring[head] = price;
		head = (head + 1) % 256;
		if (!seen) begin
			seen = 1;
			return;
		end
		n = fill;
		if (n < 2) begin
			pending_slopes.push_back('0);
			return;
		end
		a = 2 * sum_wp - longint'(n - 1) * sum_p;
		pending_slopes.push_back(divide(6 * a, n * (n * n - 1)));
	endfunction

	function void check_slope(bit [48:0] got);
		bit [48:0] want;
		if (pending_slopes.size() == 0) begin
			$display("%0t: unexpected slope %h", $time, got);
			errors++;
			return;
		end
		want = pending_slopes.pop_front();
		if (want !== got) begin
			$display("%0t: slope mismatch expected %h actual %h", $time, want, got);
			errors++;
		end
	endfunction
endclass

module tb_sliding_window_regression_slope;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] close_price = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] period = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [48:0] slope;
	bit sending_done = 0;
	slope_scoreboard sb;

	sliding_window_regression_slope u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .close_price(close_price),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .period(period),
		.out_valid(out_valid), .out_stall(out_stall), .slope(slope)
	);

	always #6 clk = ~clk;

	function automatic int unsigned gap_len();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic bit [31:0] rand_price();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 200) - 100;
			default: return $urandom();
		endcase
	endfunction

	// A request stays valid after acceptance until the next call decides
	// whether a gap follows, so each falling edge sees one assignment at most.
	task automatic send_sample(bit [31:0] price);
		int unsigned gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		close_price <= price;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(price);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending_slopes.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_period(bit [7:0] p);
		wait_drained();
		cfg_valid <= 1;
		period <= p;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_period(p);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_slope(slope);
	end

	initial begin
		int unsigned hold;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				hold = gap_len();
				out_stall <= hold != 0 && $urandom_range(0, 2) == 0;
			end
		end
	end

	initial begin
		bit [7:0] periods[8] = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd5, 8'd3, 8'd64, 8'd20};
		bit [31:0] directed[12] = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h0, 32'hffffffff, 32'h1, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h5, 32'h80000000};
		int unsigned count;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);
		foreach (directed[i])
			send_sample(directed[i]);
		for (int k = 0; k < 8; k++) begin
			write_period(periods[k]);
			for (int j = 0; j < 5; j++)
				send_sample(directed[j]);
			count = (periods[k] == 255) ? 420 : 110;
			for (int j = 0; j < count; j++) begin
				send_sample(rand_price());
				if (j == 60)
					wait_drained();
			end
		end
		write_period(8'($urandom()));
		for (int j = 0; j < 200; j++)
			send_sample(rand_price());
		wait_drained();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#60000000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
